// ===== rtl/core/pkw_pkg.sv =====
// Package for the product kernel weight block: kernel codes, register indexes,
// field widths and the constant function that builds the Gaussian density table.
// Used by pkw_lane, pkw_merge and product_kernel_weight; depends on nothing else.
package pkw_pkg;

    // Field widths.
    localparam int COORD_W     = 16;
    localparam int FACTOR_W    = 17;
    localparam int WEIGHT_W    = 18;
    localparam int KIND_W      = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 2;

    // Number of coordinate fields that one request carries.
    localparam int NUM_COORDS = 4;

    // Register stages inside one factor lane.
    localparam int LANE_STAGES = 5;

    // Defaults for the top level parameters.
    localparam int MAX_DIM_DEFAULT     = 4;
    localparam int GAUSS_DEPTH_DEFAULT = 256;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [FACTOR_W-1:0]       factor_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic [KIND_W-1:0]         kind_t;

    // Kernel kind codes.
    localparam kind_t KIND_GAUSSIAN     = 3'd0;
    localparam kind_t KIND_UNIFORM      = 3'd1;
    localparam kind_t KIND_TRIANGLE     = 3'd2;
    localparam kind_t KIND_EPANECHNIKOV = 3'd3;
    localparam kind_t KIND_BIWEIGHT     = 3'd4;
    localparam kind_t KIND_TRIWEIGHT    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_KERNEL_KIND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DIMS_IN_USE = 2'd1;

    // Weight limits in Q2.16.
    localparam weight_t WEIGHT_ONE = 18'd65536;
    localparam weight_t WEIGHT_MAX = 18'd262143;

    // Q28 constants for the density table.
    localparam logic [63:0] Q28_ONE          = 64'd268435456;
    localparam logic [63:0] Q28_MASK         = 64'd268435455;
    localparam logic [63:0] LOG2E_Q28        = 64'd387270501;
    localparam logic [63:0] LN2_Q28          = 64'd186065280;
    localparam logic [63:0] INV_SQRT_2PI_Q28 = 64'd107090253;

    // Standard normal density in Q16 for t = x*x/2 given in Q28. The value is
    // 2^-y with y = t*log2(e), split into an integer shift and a fractional
    // part whose power of two comes from a twelve-term Horner series.
    function automatic factor_t gauss_entry(input logic [63:0] t_q28);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] g;
        logic [63:0] z;
        logic [63:0] r;
        logic [63:0] ec;
        logic [63:0] sh;
        factor_t     result;
        y = (t_q28 * LOG2E_Q28) >> 28;
        n = y >> 28;
        g = y & Q28_MASK;
        z = (g * LN2_Q28) >> 28;
        r = Q28_ONE;
        r = Q28_ONE - ((z * r) >> 28) / 64'd12;
        r = Q28_ONE - ((z * r) >> 28) / 64'd11;
        r = Q28_ONE - ((z * r) >> 28) / 64'd10;
        r = Q28_ONE - ((z * r) >> 28) / 64'd9;
        r = Q28_ONE - ((z * r) >> 28) / 64'd8;
        r = Q28_ONE - ((z * r) >> 28) / 64'd7;
        r = Q28_ONE - ((z * r) >> 28) / 64'd6;
        r = Q28_ONE - ((z * r) >> 28) / 64'd5;
        r = Q28_ONE - ((z * r) >> 28) / 64'd4;
        r = Q28_ONE - ((z * r) >> 28) / 64'd3;
        r = Q28_ONE - ((z * r) >> 28) / 64'd2;
        r = Q28_ONE - ((z * r) >> 28);
        ec = r * INV_SQRT_2PI_Q28;
        sh = 64'd40 + n;
        if (n >= 64'd24)
        begin
            result = '0;
        end
        else
        begin
            result = FACTOR_W'((ec + (64'd1 << (sh - 64'd1))) >> sh);
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/pkw_lane.sv =====
// One factor lane: turns a Q3.12 coordinate into its Q16 kernel factor over five
// register stages. Depends on pkw_pkg for types, kernel codes and the density table.
module pkw_lane #(
    parameter int GAUSS_TABLE_DEPTH = pkw_pkg::GAUSS_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic [pkw_pkg::LANE_STAGES-1:0]     en,
    input  pkw_pkg::kind_t                      kind,
    input  pkw_pkg::coord_t                     coord,
    output pkw_pkg::factor_t                    factor
);

    localparam int IDX_W  = $clog2(GAUSS_TABLE_DEPTH);
    localparam int PROD_W = 17 + $clog2(GAUSS_TABLE_DEPTH + 1);
    localparam int FULL_W = PROD_W - 15;
    localparam logic [63:0] GAUSS_DEPTH_SQ =
        64'(GAUSS_TABLE_DEPTH) * 64'(GAUSS_TABLE_DEPTH);

    // Density table, built at elaboration; entry i covers |u| = 8i/depth.
    pkw_pkg::factor_t gauss_rom [GAUSS_TABLE_DEPTH];

    for (genvar i = 0; i < GAUSS_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] T_Q28 = ((64'd32 * 64'(i) * 64'(i)) << 28) / GAUSS_DEPTH_SQ;
        localparam pkw_pkg::factor_t ENTRY = pkw_pkg::gauss_entry(T_Q28);
        assign gauss_rom[i] = ENTRY;
    end

    // Stage 1: magnitude, support test, table lookup and s = 1 - u*u in Q24.
    logic [15:0]       raw;
    logic [16:0]       mag;
    logic [PROD_W-1:0] idx_prod;
    logic [FULL_W-1:0] idx_full;
    logic [IDX_W-1:0]  idx;
    logic [12:0]       a13;
    logic [25:0]       a_sq;
    logic [24:0]       s_val;
    logic              in_support;

    always_comb
    begin
        raw      = coord;
        mag      = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        idx_prod = PROD_W'(mag) * PROD_W'(GAUSS_TABLE_DEPTH);
        idx_full = idx_prod[PROD_W-1:15];
        if (idx_full >= FULL_W'(GAUSS_TABLE_DEPTH))
        begin
            idx = IDX_W'(GAUSS_TABLE_DEPTH - 1);
        end
        else
        begin
            idx = idx_full[IDX_W-1:0];
        end
        in_support = (mag <= 17'd4096);
        a13        = mag[12:0];
        a_sq       = 26'(a13) * 26'(a13);
        s_val      = 25'(26'h1000000 - a_sq);
    end

    logic [12:0]      a1_reg;
    logic [24:0]      s1_reg;
    logic             in_support1_reg;
    pkw_pkg::factor_t gauss1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a1_reg          <= a13;
            s1_reg          <= s_val;
            in_support1_reg <= in_support;
            gauss1_reg      <= gauss_rom[idx];
        end
    end

    // Stage 2: square of s, and the factors that need no multiplier.
    logic [48:0]      sq_next;
    logic [26:0]      epan_sum;
    pkw_pkg::factor_t tri_f;
    pkw_pkg::factor_t epan_f;
    pkw_pkg::factor_t simple_next;

    always_comb
    begin
        sq_next  = 49'(s1_reg) * 49'(s1_reg);
        epan_sum = 27'(s1_reg) * 27'd3 + 27'd512;
        epan_f   = 17'(epan_sum >> 10);
        tri_f    = 17'(13'd4096 - a1_reg) << 4;
        case (kind)
            pkw_pkg::KIND_GAUSSIAN:     simple_next = gauss1_reg;
            pkw_pkg::KIND_UNIFORM:      simple_next = 17'd32768;
            pkw_pkg::KIND_TRIANGLE:     simple_next = tri_f;
            pkw_pkg::KIND_EPANECHNIKOV: simple_next = epan_f;
            default:                    simple_next = '0;
        endcase
    end

    logic [48:0]      sq2_reg;
    logic [24:0]      s2_reg;
    logic             in_support2_reg;
    pkw_pkg::factor_t simple2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sq2_reg         <= sq_next;
            s2_reg          <= s1_reg;
            in_support2_reg <= in_support1_reg;
            simple2_reg     <= simple_next;
        end
    end

    // Stage 3: biweight factor and the rounded Q24 square for the triweight.
    logic [48:0] ssq_sum;
    logic [52:0] bi_sum;

    always_comb
    begin
        ssq_sum = sq2_reg + 49'h0000000800000;
        bi_sum  = 53'(sq2_reg) * 53'd15 + 53'h00000800000000;
    end

    logic [24:0]      ssq3_reg;
    logic [24:0]      s3_reg;
    pkw_pkg::factor_t bi3_reg;
    pkw_pkg::factor_t simple3_reg;
    logic             in_support3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ssq3_reg        <= 25'(ssq_sum >> 24);
            s3_reg          <= s2_reg;
            bi3_reg         <= 17'(bi_sum >> 36);
            simple3_reg     <= simple2_reg;
            in_support3_reg <= in_support2_reg;
        end
    end

    // Stage 4: cube of s for the triweight.
    logic [48:0]      m4_reg;
    pkw_pkg::factor_t bi4_reg;
    pkw_pkg::factor_t simple4_reg;
    logic             in_support4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            m4_reg          <= 49'(ssq3_reg) * 49'(s3_reg);
            bi4_reg         <= bi3_reg;
            simple4_reg     <= simple3_reg;
            in_support4_reg <= in_support3_reg;
        end
    end

    // Stage 5: triweight scaling and the final factor choice. Outside the
    // support a compact kernel gives zero, which zeroes the whole product.
    logic [54:0]      tw_sum;
    pkw_pkg::factor_t tw_f;
    pkw_pkg::factor_t factor_next;

    always_comb
    begin
        tw_sum = 55'(m4_reg) * 55'd35 + 55'h00001000000000;
        tw_f   = 17'(tw_sum >> 37);
        case (kind)
            pkw_pkg::KIND_BIWEIGHT:  factor_next = bi4_reg;
            pkw_pkg::KIND_TRIWEIGHT: factor_next = tw_f;
            default:                 factor_next = simple4_reg;
        endcase
        if ((kind != pkw_pkg::KIND_GAUSSIAN) && !in_support4_reg)
        begin
            factor_next = '0;
        end
    end

    pkw_pkg::factor_t factor_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            factor_reg <= factor_next;
        end
    end

    assign factor = factor_reg;

endmodule

// ===== rtl/core/pkw_merge.sv =====
// Merging chain: multiplies the lane factors into the Q2.16 weight, one dimension
// per register stage, with rounding and saturation. Depends on pkw_pkg.
module pkw_merge #(
    parameter int LANES = pkw_pkg::NUM_COORDS
) (
    input  logic                          clk,
    input  logic [LANES-1:0]              en,
    input  logic [$clog2(LANES+1)-1:0]    dims,
    input  pkw_pkg::factor_t              fac_in [LANES],
    output pkw_pkg::weight_t              weight
);

    localparam int DIMW = $clog2(LANES + 1);

    pkw_pkg::weight_t w_reg   [LANES];
    pkw_pkg::factor_t fac_reg [LANES][LANES];

    for (genvar j = 0; j < LANES; j++)
    begin : g_stage
        pkw_pkg::weight_t w_in;
        pkw_pkg::factor_t f_in;
        pkw_pkg::factor_t f_row [LANES];
        logic [34:0]      prod;
        logic [18:0]      rnd;
        pkw_pkg::weight_t w_step;

        // The first stage starts from a weight of one; later ones take the
        // running weight and the factors carried along beside it.
        if (j == 0)
        begin : g_first
            assign w_in  = pkw_pkg::WEIGHT_ONE;
            assign f_in  = fac_in[0];
            assign f_row = fac_in;
        end
        else
        begin : g_next
            assign w_in  = w_reg[j-1];
            assign f_in  = fac_reg[j-1][j];
            assign f_row = fac_reg[j-1];
        end

        // Round half up, saturate, and skip the dimensions not in use.
        always_comb
        begin
            prod = 35'(w_in) * 35'(f_in) + 35'd32768;
            rnd  = prod[34:16];
            if (DIMW'(j) >= dims)
            begin
                w_step = w_in;
            end
            else if (rnd > 19'(pkw_pkg::WEIGHT_MAX))
            begin
                w_step = pkw_pkg::WEIGHT_MAX;
            end
            else
            begin
                w_step = rnd[17:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                w_reg[j]   <= w_step;
                fac_reg[j] <= f_row;
            end
        end
    end

    assign weight = w_reg[LANES-1];

endmodule

// ===== rtl/core/product_kernel_weight.sv =====
// Top level of the product kernel weight block: configuration registers,
// pipeline flow control, the factor lanes and the merging chain.
// Depends on pkw_pkg, pkw_lane and pkw_merge.
//
//  Channel   Direction  Handshake             Payload
//  s_*       in         s_tvalid / s_tready   s_tdata: coord_0..coord_3, 16 bits each
//  m_*       out        m_tvalid / m_tready   m_tdata: weight, 18 bits
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken per cycle while s_tready is high; each weight passes five
// stages in every factor lane, set by the two chained multiplies of the
// triweight, then one merge stage per supported dimension.
// Reset clears only control state and the registers; there is no clearing pass.
// A stall on the output holds the last stage; earlier stages keep filling empty
// slots, so s_tready falls only once every stage holds a request.
module product_kernel_weight #(
    parameter int MAX_DIM           = pkw_pkg::MAX_DIM_DEFAULT,
    parameter int GAUSS_TABLE_DEPTH = pkw_pkg::GAUSS_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Bits from low: coord_0 [15:0], coord_1 [31:16], coord_2 [47:32],
    // coord_3 [63:48].
    input  logic [63:0]                        s_tdata,
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Bits from low: weight [17:0], zero fill [23:18].
    output logic [23:0]                        m_tdata,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pkw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pkw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LANES = (MAX_DIM < pkw_pkg::NUM_COORDS) ? MAX_DIM : pkw_pkg::NUM_COORDS;
    localparam int DIMW  = $clog2(LANES + 1);
    localparam int NST   = pkw_pkg::LANE_STAGES + LANES;

    // Configuration registers; the dimension count is stored already clamped.
    pkw_pkg::kind_t  kind_reg;
    logic [DIMW-1:0] dims_reg;
    logic [DIMW-1:0] dims_next;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            dims_next = DIMW'(1);
        end
        else if (cfg_data > pkw_pkg::CFG_DATA_W'(LANES))
        begin
            dims_next = DIMW'(LANES);
        end
        else
        begin
            dims_next = DIMW'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= pkw_pkg::KIND_EPANECHNIKOV;
            dims_reg <= DIMW'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pkw_pkg::CFG_IDX_KERNEL_KIND: kind_reg <= cfg_data;
                pkw_pkg::CFG_IDX_DIMS_IN_USE: dims_reg <= dims_next;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Flow control: a stage loads when it is empty or its content moves on.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];

    // Factor lanes, one per supported coordinate, whatever the dimensions in use.
    pkw_pkg::factor_t lane_factor [LANES];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        pkw_lane #(
            .GAUSS_TABLE_DEPTH (GAUSS_TABLE_DEPTH)
        ) u_lane (
            .clk    (clk),
            .en     (en[pkw_pkg::LANE_STAGES-1:0]),
            .kind   (kind_reg),
            .coord  (s_tdata[k*pkw_pkg::COORD_W +: pkw_pkg::COORD_W]),
            .factor (lane_factor[k])
        );
    end

    // Product of the factors; its last stage is the output register.
    pkw_pkg::weight_t weight;

    pkw_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk    (clk),
        .en     (en[NST-1:pkw_pkg::LANE_STAGES]),
        .dims   (dims_reg),
        .fac_in (lane_factor),
        .weight (weight)
    );

    assign m_tdata = {6'd0, weight};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for product_kernel_weight: drives coordinate requests and
// register writes, predicts each weight in fixed point and checks the results.
// Depends on pkw_pkg and the product_kernel_weight RTL.
module testbench;

    localparam int MAX_DIM     = 4;
    localparam int GAUSS_DEPTH = 256;
    localparam int DIM_LIMIT   =
        (MAX_DIM < pkw_pkg::NUM_COORDS) ? MAX_DIM : pkw_pkg::NUM_COORDS;

    // Fixed point constants of the density table, Q28.
    localparam logic [63:0] Q28_UNIT      = 64'd268435456;
    localparam logic [63:0] Q28_FRAC      = 64'd268435455;
    localparam logic [63:0] LOG2E_FIX     = 64'd387270501;
    localparam logic [63:0] LN2_FIX       = 64'd186065280;
    localparam logic [63:0] INV_ROOT2PI   = 64'd107090253;
    localparam logic [63:0] DEPTH_WIDE    = 64'(GAUSS_DEPTH);
    localparam logic [63:0] WEIGHT_LIMIT  = 64'd262143;

    // Kernel codes with no kernel behind them; they yield a zero weight.
    localparam pkw_pkg::kind_t KIND_UNDEF_LOW  = 3'd6;
    localparam pkw_pkg::kind_t KIND_UNDEF_HIGH = 3'd7;

    // Register indexes past the end of the register list.
    localparam logic [pkw_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_LOW  = 2'd2;
    localparam logic [pkw_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_HIGH = 2'd3;

    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 5 + DIM_LIMIT + 10;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [63:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [23:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pkw_pkg::CFG_INDEX_W-1:0] cfg_index = pkw_pkg::CFG_IDX_KERNEL_KIND;
    logic [pkw_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies used by the weight predictor.
    pkw_pkg::kind_t                  kind_reg  = pkw_pkg::KIND_EPANECHNIKOV;
    logic [pkw_pkg::CFG_DATA_W-1:0]  dims_reg  = 3'd1;

    logic [63:0]                     coord_queue[$];
    pkw_pkg::weight_t                weight_expect[$];

    int unsigned            send_idle_pct     = 0;
    int unsigned            recv_stall_pct    = 0;
    logic                   long_hold_request = 1'b0;
    logic                   long_hold_started = 1'b0;
    int unsigned            hold_left         = 0;
    int unsigned            quiet_cycles      = 0;
    int unsigned            errors            = 0;
    int unsigned            requests_sent     = 0;
    int unsigned            weights_checked   = 0;
    int unsigned            cfg_writes        = 0;

    product_kernel_weight #(
        .MAX_DIM           (MAX_DIM),
        .GAUSS_TABLE_DEPTH (GAUSS_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Standard normal density in Q16 at x = 8*slot/depth, as 2^-(x*x/2*log2 e)
    // with the fractional power taken from a Horner series of exp.
    function automatic logic [63:0] normal_density_q16(input logic [63:0] slot);
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] g;
        logic [63:0] z;
        logic [63:0] r;
        logic [63:0] shift;
        logic [63:0] density;
        t = ((64'd32 * slot * slot) << 28) / (DEPTH_WIDE * DEPTH_WIDE);
        y = (t * LOG2E_FIX) >> 28;
        n = y >> 28;
        g = y & Q28_FRAC;
        if (n >= 64'd24)
        begin
            density = '0;
        end
        else
        begin
            z = (g * LN2_FIX) >> 28;
            r = Q28_UNIT;
            for (int k = 12; k >= 1; k--)
            begin
                r = Q28_UNIT - ((z * r) >> 28) / 64'(k);
            end
            shift   = 64'd40 + n;
            density = (r * INV_ROOT2PI + (64'd1 << (shift - 64'd1))) >> shift;
        end
        return density;
    endfunction

    // One dimension's factor in Q16; beyond flags |u| > 1 for compact kernels.
    function automatic logic [63:0] kernel_factor(input pkw_pkg::kind_t kind,
                                                  input pkw_pkg::coord_t u,
                                                  output bit beyond);
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] slot;
        logic [63:0] f;
        a      = u[15] ? (64'h10000 - {48'd0, u}) : {48'd0, u};
        beyond = 1'b0;
        f      = '0;
        if (kind == pkw_pkg::KIND_GAUSSIAN)
        begin
            slot = (a * DEPTH_WIDE) >> 15;
            if (slot >= DEPTH_WIDE)
            begin
                slot = DEPTH_WIDE - 64'd1;
            end
            f = normal_density_q16(slot);
        end
        else if (a > 64'd4096)
        begin
            beyond = 1'b1;
        end
        else
        begin
            s = (64'd1 << 24) - a * a;
            case (kind)
                pkw_pkg::KIND_UNIFORM:      f = 64'd32768;
                pkw_pkg::KIND_TRIANGLE:     f = (64'd4096 - a) << 4;
                pkw_pkg::KIND_EPANECHNIKOV: f = (64'd3 * s + (64'd1 << 9)) >> 10;
                pkw_pkg::KIND_BIWEIGHT:     f = (64'd15 * s * s + (64'd1 << 35)) >> 36;
                pkw_pkg::KIND_TRIWEIGHT:
                begin
                    s2 = (s * s + (64'd1 << 23)) >> 24;
                    f  = (64'd35 * s2 * s + (64'd1 << 36)) >> 37;
                end
                default:                    f = '0;
            endcase
        end
        return f;
    endfunction

    // Product of the factors over the dimensions in use, under the current registers.
    function automatic pkw_pkg::weight_t predict_weight(input logic [63:0] coords);
        int          dims;
        logic [63:0] w;
        logic [63:0] f;
        bit          beyond;
        bit          vanished;
        dims = int'(dims_reg);
        if (dims < 1)
        begin
            dims = 1;
        end
        if (dims > DIM_LIMIT)
        begin
            dims = DIM_LIMIT;
        end
        w        = 64'd65536;
        vanished = (kind_reg > pkw_pkg::KIND_TRIWEIGHT);
        for (int i = 0; i < dims && !vanished; i++)
        begin
            f = kernel_factor(kind_reg, pkw_pkg::coord_t'(coords[16*i +: 16]), beyond);
            if (beyond)
            begin
                vanished = 1'b1;
            end
            else
            begin
                w = (w * f + 64'd32768) >> 16;
                if (w > WEIGHT_LIMIT)
                begin
                    w = WEIGHT_LIMIT;
                end
            end
        end
        if (vanished)
        begin
            w = '0;
        end
        return pkw_pkg::weight_t'(w);
    endfunction

    // Coordinates mostly near the unit support, some corners, some full range.
    function automatic pkw_pkg::coord_t pick_coord();
        int unsigned     roll;
        pkw_pkg::coord_t c;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            case ($urandom_range(8))
                0:       c = 16'sd0;
                1:       c = 16'sd4096;
                2:       c = -16'sd4096;
                3:       c = 16'sd4097;
                4:       c = -16'sd4097;
                5:       c = 16'sd32767;
                6:       c = 16'h8000;
                7:       c = 16'sd1;
                default: c = -16'sd1;
            endcase
        end
        else if (roll < 75)
        begin
            c = pkw_pkg::coord_t'($urandom_range(8400) - 4200);
        end
        else
        begin
            c = pkw_pkg::coord_t'($urandom());
        end
        return c;
    endfunction

    // Request driver: predicts each accepted request and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                weight_expect.push_back(predict_weight(s_tdata));
                requests_sent++;
            end
            if (coord_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= coord_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom(), $urandom()};
            end
        end
    end

    // Result monitor: checks weights in order and paces m_tready.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        pkw_pkg::weight_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                weights_checked++;
                if (weight_expect.size() == 0)
                begin
                    $error("weight: unexpected result %0d", m_tdata[pkw_pkg::WEIGHT_W-1:0]);
                    errors++;
                end
                else
                begin
                    due = weight_expect.pop_front();
                    if (m_tdata[pkw_pkg::WEIGHT_W-1:0] !== due)
                    begin
                        $error("weight: expected %0d, actual %0d", due,
                               m_tdata[pkw_pkg::WEIGHT_W-1:0]);
                        errors++;
                    end
                end
            end
            // A long hold lets the pipeline fill and push back on requests.
            if (long_hold_request && !long_hold_started)
            begin
                long_hold_started <= 1'b1;
                hold_left         <= LONG_HOLD;
                m_tready          <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("testbench: FAIL");
                    $finish;
                end
            end
        end
    end

    // Waits until no request is pending or in flight and every weight has come.
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (coord_queue.size() != 0 || s_tvalid || weight_expect.size() != 0);
    endtask

    task automatic write_register(input logic [pkw_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [pkw_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == pkw_pkg::CFG_IDX_KERNEL_KIND)
        begin
            kind_reg = pkw_pkg::kind_t'(value);
        end
        else if (index == pkw_pkg::CFG_IDX_DIMS_IN_USE)
        begin
            dims_reg = value;
        end
        cfg_writes++;
    endtask

    // Boundary vectors: |u| == 1 in three slots, small values, and the extremes.
    task automatic push_corner_items();
        coord_queue.push_back({-16'sd4096, 16'sd0, -16'sd4096, 16'sd4096});
        coord_queue.push_back({16'sd2048, -16'sd1, 16'sd1, 16'sd0});
        coord_queue.push_back({-16'sd4097, 16'sd4097, 16'sd32767, 16'h8000});
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            coord_queue.push_back({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
        end
    endtask

    // One register setting: reconfigure while idle, then stream requests in two
    // halves with a full drain in between.
    task automatic run_phase(input bit reconfigure, input pkw_pkg::kind_t kind,
                             input logic [pkw_pkg::CFG_DATA_W-1:0] dims,
                             input idle_mode_t mode, input bit corners,
                             input int n_random, input bit long_hold);
        wait_idle();
        if (reconfigure)
        begin
            write_register(pkw_pkg::CFG_IDX_KERNEL_KIND, kind);
            write_register(pkw_pkg::CFG_IDX_DIMS_IN_USE, dims);
        end
        @(negedge clk);
        send_idle_pct  <= (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 38 : 0;
        recv_stall_pct <= (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 38 : 0;
        if (long_hold)
        begin
            long_hold_request <= 1'b1;
        end
        if (corners)
        begin
            push_corner_items();
        end
        push_random(n_random / 2);
        wait_idle();
        push_random(n_random - n_random / 2);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: boundary vectors under every kernel code.
        run_phase(1'b0, pkw_pkg::KIND_EPANECHNIKOV, 3'd1, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_GAUSSIAN,     3'd4, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_UNIFORM,      3'd4, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_TRIANGLE,     3'd3, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_BIWEIGHT,     3'd2, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_TRIWEIGHT,    3'd4, IDLE_NONE, 1'b1, 0, 1'b0);
        run_phase(1'b1, KIND_UNDEF_LOW,             3'd1, IDLE_NONE, 1'b1, 0, 1'b0);
        wait_idle();
        write_register(CFG_IDX_SPARE_LOW, 3'd7);
        write_register(CFG_IDX_SPARE_HIGH, 3'd7);
        run_phase(1'b1, KIND_UNDEF_HIGH,            3'd0, IDLE_NONE, 1'b1, 0, 1'b0);

        // Random part across settings and idle patterns.
        run_phase(1'b1, pkw_pkg::KIND_EPANECHNIKOV, 3'd4, IDLE_NONE,     1'b0, 75, 1'b1);
        run_phase(1'b1, pkw_pkg::KIND_GAUSSIAN,     3'd4, IDLE_SENDER,   1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_TRIWEIGHT,    3'd7, IDLE_RECEIVER, 1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_UNIFORM,      3'd4, IDLE_BOTH,     1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_TRIANGLE,     3'd2, IDLE_NONE,     1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_BIWEIGHT,     3'd4, IDLE_SENDER,   1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_GAUSSIAN,     3'd1, IDLE_RECEIVER, 1'b0, 75, 1'b0);
        run_phase(1'b1, pkw_pkg::KIND_EPANECHNIKOV, 3'd0, IDLE_BOTH,     1'b0, 75, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (weight_expect.size() != 0)
        begin
            $error("weight: %0d results never arrived", weight_expect.size());
            errors++;
        end
        $display("summary: %0d requests sent, %0d weights checked, %0d register writes",
                 requests_sent, weights_checked, cfg_writes);
        $display("summary: all kernel codes, dims 0 to 7, backpressure and idle patterns");
        if (errors == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pkw_pkg.sv
rtl/core/pkw_lane.sv
rtl/core/pkw_merge.sv
rtl/core/product_kernel_weight.sv
tb/sv/testbench.sv
